### rtl/bga_pkg.sv
// Shared types and constants for the battery gauge block.
`default_nettype none
package bga_pkg;

    // Block length default and the fixed scaling of the gain register
    localparam int DEFAULT_SAMPLE_COUNT = 16;
    localparam int GAIN_FRAC_W          = 12;

    // Field widths
    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 16;
    localparam int PCT_W     = 7;
    localparam int PROD_W    = 2 * CFG_W;
    localparam int DIV_W     = CFG_W + PCT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [PCT_W-1:0] FULL_PERCENT = PCT_W'(100);

    // Register indexes
    localparam logic [1:0] REG_SCALE_GAIN   = 2'd0;
    localparam logic [1:0] REG_VOLTAGE_MIN  = 2'd1;
    localparam logic [1:0] REG_VOLTAGE_MAX  = 2'd2;
    localparam logic [1:0] REG_GUARD_MARGIN = 2'd3;

    // Reset values
    localparam logic [CFG_W-1:0] RST_SCALE_GAIN   = 16'd8192;
    localparam logic [CFG_W-1:0] RST_VOLTAGE_MIN  = 16'd3000;
    localparam logic [CFG_W-1:0] RST_VOLTAGE_MAX  = 16'd4200;
    localparam logic [CFG_W-1:0] RST_GUARD_MARGIN = 16'd500;

    typedef struct packed {
        logic [CFG_W-1:0] scale_gain;
        logic [CFG_W-1:0] voltage_min_mv;
        logic [CFG_W-1:0] voltage_max_mv;
        logic [CFG_W-1:0] guard_margin_mv;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_VLOAD,
        S_VSAT,
        S_PMUL,
        S_PLOAD,
        S_PDIV,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic acc;       // add accepted sample to the block sum
        logic mul;       // register sum * gain, clear block sum
        logic vload;     // register voltage quotient (reciprocal multiply)
        logic pload;     // start percent division
        logic div_step;  // one quotient bit
        logic vsat;      // register saturated voltage
        logic pmul;      // register percent numerator
        logic out_load;  // write result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;      // next sample closes the block
        logic div_done;
        logic between;   // voltage strictly between min and max
        logic out_free;  // result register can take a new result
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/bga_if.sv
// Stream interfaces for the sample input and the gauge result.
`default_nettype none
interface bga_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bga_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] voltage_mv;
    logic [6:0]  charge_percent;
    logic        reading_valid;

    modport source (output valid, output voltage_mv, output charge_percent,
                    output reading_valid, input ready);
    modport sink   (input valid, input voltage_mv, input charge_percent,
                    input reading_valid, output ready);
endinterface
`default_nettype wire

### rtl/bga_regs.sv
// APB-style configuration registers of the battery gauge.
`default_nettype none
module bga_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bga_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bga_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bga_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output bga_pkg::t_cfg                       o_cfg
);
    import bga_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_gain      <= RST_SCALE_GAIN;
            r_cfg.voltage_min_mv  <= RST_VOLTAGE_MIN;
            r_cfg.voltage_max_mv  <= RST_VOLTAGE_MAX;
            r_cfg.guard_margin_mv <= RST_GUARD_MARGIN;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SCALE_GAIN:   r_cfg.scale_gain      <= pwdata[CFG_W-1:0];
                REG_VOLTAGE_MIN:  r_cfg.voltage_min_mv  <= pwdata[CFG_W-1:0];
                REG_VOLTAGE_MAX:  r_cfg.voltage_max_mv  <= pwdata[CFG_W-1:0];
                REG_GUARD_MARGIN: r_cfg.guard_margin_mv <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_SCALE_GAIN:   prdata = APB_DATA_W'(r_cfg.scale_gain);
            REG_VOLTAGE_MIN:  prdata = APB_DATA_W'(r_cfg.voltage_min_mv);
            REG_VOLTAGE_MAX:  prdata = APB_DATA_W'(r_cfg.voltage_max_mv);
            REG_GUARD_MARGIN: prdata = APB_DATA_W'(r_cfg.guard_margin_mv);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/bga_ctrl.sv
// Sequencer of the battery gauge: block accumulation and result computation.
`default_nettype none
module bga_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire bga_pkg::t_dp_sts i_sts,
    output bga_pkg::t_dp_cmd      o_cmd
);
    import bga_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && i_sts.last) n_state = S_MUL;
            S_MUL:   n_state = S_VLOAD;
            S_VLOAD: n_state = S_VSAT;
            S_VSAT:  n_state = S_PMUL;
            S_PMUL:  n_state = S_PLOAD;
            S_PLOAD: n_state = i_sts.between ? S_PDIV : S_DONE;
            S_PDIV:  if (i_sts.div_done) n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:  o_cmd.acc      = accept;
            S_MUL:   o_cmd.mul      = 1'b1;
            S_VLOAD: o_cmd.vload    = 1'b1;
            S_VSAT:  o_cmd.vsat     = 1'b1;
            S_PMUL:  o_cmd.pmul     = 1'b1;
            S_PLOAD: o_cmd.pload    = i_sts.between;
            S_PDIV:  o_cmd.div_step = !i_sts.div_done;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/bga_dp.sv
// Datapath of the battery gauge: block sum, scaling, bit-serial divider, result register.
`default_nettype none
module bga_dp #(
    parameter int SAMPLE_COUNT = bga_pkg::DEFAULT_SAMPLE_COUNT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [bga_pkg::SAMPLE_W-1:0] i_sample_mv,
    input  wire bga_pkg::t_cfg                i_cfg,
    input  wire bga_pkg::t_dp_cmd             i_cmd,
    output bga_pkg::t_dp_sts                  o_sts,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [bga_pkg::CFG_W-1:0]         o_voltage_mv,
    output logic [bga_pkg::PCT_W-1:0]         o_charge_percent,
    output logic                              o_reading_valid
);
    import bga_pkg::*;

    localparam int IDX_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLE_COUNT - 1);

    // Division by the block length as a multiply by ceil(2^k / n); exact for
    // every scaled sum below 2^SCALED_W since n <= 2^IDX_W
    localparam int SCALED_W    = PROD_W - GAIN_FRAC_W;
    localparam int RECIP_SHIFT = SCALED_W + IDX_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] BLOCK_RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(SAMPLE_COUNT) - 1)
                 / longint'(SAMPLE_COUNT));

    // Block accumulation
    logic [CFG_W-1:0]     r_sum;
    logic [IDX_W-1:0]     r_idx;
    // Scaling and divider
    logic [PROD_W-1:0]    r_prod;
    logic [DIV_W-1:0]     r_quo;
    logic [CFG_W-1:0]     r_rem;
    logic [CFG_W-1:0]     r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CFG_W-1:0]     r_volt;
    logic [DIV_W-1:0]     r_num;
    // Result register
    logic                 r_out_valid;
    logic [CFG_W-1:0]     r_out_volt;
    logic [PCT_W-1:0]     r_out_pct;
    logic                 r_out_ok;

    logic                 last;
    logic [SCALED_W+RECIP_W-1:0] scaled;
    logic [CFG_W:0]       trial;
    logic                 fits;
    logic                 full;
    logic                 empty;
    logic                 low_fail;
    logic                 high_fail;
    logic                 ok;
    logic [CFG_W-1:0]     volt_sat;
    logic [PCT_W-1:0]     pct;

    assign last = (r_idx == LAST_IDX);

    // Sum of the current block, 16-bit wrap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_idx <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + CFG_W'(i_sample_mv);
            r_idx <= last ? '0 : r_idx + 1'b1;
        end else if (i_cmd.mul) begin
            r_sum <= '0;
        end
    end

    // Sum times gain
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_sum * i_cfg.scale_gain;
        end
    end

    // Drop the gain fraction, then divide by the block length
    assign scaled = r_prod[PROD_W-1:GAIN_FRAC_W] * BLOCK_RECIP;

    // Restoring divider for the percent fraction, one quotient bit per cycle
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign fits  = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.pload) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vload) begin
            r_quo <= DIV_W'(scaled[SCALED_W+RECIP_W-1:RECIP_SHIFT]);
        end else if (i_cmd.pload) begin
            r_rem <= '0;
            r_quo <= r_num;
            r_dsr <= i_cfg.voltage_max_mv - i_cfg.voltage_min_mv;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? CFG_W'(trial - {1'b0, r_dsr}) : trial[CFG_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    // Voltage saturates at the top of 16 bits
    assign volt_sat = (|r_quo[DIV_W-1:CFG_W]) ? '1 : r_quo[CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.vsat) begin
            r_volt <= volt_sat;
        end
    end

    // Percent numerator (v - min) * 100
    always_ff @(posedge i_clk) begin
        if (i_cmd.pmul) begin
            r_num <= (r_volt - i_cfg.voltage_min_mv) * FULL_PERCENT;
        end
    end

    // Range tests, full wins over empty
    assign full  = (r_volt >= i_cfg.voltage_max_mv);
    assign empty = !full && (r_volt <= i_cfg.voltage_min_mv);

    // Plausibility guard in 17 bits, no wrap
    assign low_fail  = ({1'b0, r_volt} + {1'b0, i_cfg.guard_margin_mv})
                       < {1'b0, i_cfg.voltage_min_mv};
    assign high_fail = {1'b0, r_volt}
                       > ({1'b0, i_cfg.voltage_max_mv} + {1'b0, i_cfg.guard_margin_mv});
    assign ok        = !(low_fail || high_fail);

    always_comb begin
        if (full) begin
            pct = FULL_PERCENT;
        end else if (empty) begin
            pct = '0;
        end else begin
            pct = r_quo[PCT_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_volt <= ok ? r_volt : '0;
            r_out_pct  <= ok ? pct : '0;
            r_out_ok   <= ok;
        end
    end

    assign o_sts.last     = last;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.between  = !full && !empty;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_voltage_mv     = r_out_volt;
    assign o_charge_percent = r_out_pct;
    assign o_reading_valid  = r_out_ok;

endmodule
`default_nettype wire

### rtl/battery_gauge_average_percent_core.sv
// Battery gauge top level: block-averaged battery voltage and linear charge percent.
// Each input transfer carries one pin reading in mV; SAMPLE_COUNT readings form a
// block and only the last one of a block produces a result transfer. A reading that
// does not close a block leaves the input open. After the closing reading the input
// stays closed until the result is loaded into the output register, through the sum
// times gain product, the division by the block length (a multiply by a constant
// reciprocal), saturation, the percent numerator and the range check, then a
// bit-serial restoring divider (23 quotient bits) only when the voltage lies
// strictly between minimum and maximum, and the result load. The load waits while the
// previous result still waits in the output register. Further readings of the next
// block are taken while a result waits to be collected. Configuration is written
// through the APB-style port while the block is idle; registers sit at byte
// addresses 0, 4, 8 and 12. The block itself does not enforce the idle condition.
`default_nettype none
module battery_gauge_average_percent_core #(
    parameter int SAMPLE_COUNT = bga_pkg::DEFAULT_SAMPLE_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bga_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bga_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bga_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    bga_in_if.sink                              i_in,
    bga_out_if.source                           o_out
);
    import bga_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // Configuration registers
    bga_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    bga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // Datapath
    bga_dp #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_mv      (i_in.sample_mv),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_voltage_mv     (o_out.voltage_mv),
        .o_charge_percent (o_out.charge_percent),
        .o_reading_valid  (o_out.reading_valid)
    );

endmodule
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the battery gauge core: block sums, voltage, percent and guard.
`timescale 1ns / 1ps
module testbench;
    import bga_pkg::*;

    localparam int BLOCK_LEN       = DEFAULT_SAMPLE_COUNT;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int NUM_PHASES      = 7;
    localparam int BLOCKS_PER_PHASE = 5;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_OFF_CYCLES = 400;

    // One gauge reading as it leaves the block
    typedef struct {
        logic [CFG_W-1:0] voltage_mv;
        logic [PCT_W-1:0] charge_percent;
        logic             reading_valid;
    } t_gauge_reading;

    // Where a targeted block aims its voltage
    typedef enum int {
        AIM_MIN, AIM_MAX, AIM_LOW_EDGE, AIM_BELOW_LOW, AIM_HIGH_EDGE,
        AIM_ABOVE_HIGH, AIM_MIN_UP, AIM_MAX_DOWN, AIM_BETWEEN, AIM_ANY
    } t_aim;

    // Tracks block sums and holds the readings still owed by the block
    class t_gauge_checker;
        logic [CFG_W-1:0] cfg_gain;
        logic [CFG_W-1:0] cfg_min_mv;
        logic [CFG_W-1:0] cfg_max_mv;
        logic [CFG_W-1:0] cfg_margin_mv;
        logic [CFG_W-1:0] block_sum;
        int               block_pos;
        int               block_len;
        t_gauge_reading   owed_readings[$];
        int               error_count;

        function new(int len);
            cfg_gain      = RST_SCALE_GAIN;
            cfg_min_mv    = RST_VOLTAGE_MIN;
            cfg_max_mv    = RST_VOLTAGE_MAX;
            cfg_margin_mv = RST_GUARD_MARGIN;
            block_sum     = '0;
            block_pos     = 0;
            block_len     = len;
            error_count   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SCALE_GAIN:   cfg_gain      = val;
                REG_VOLTAGE_MIN:  cfg_min_mv    = val;
                REG_VOLTAGE_MAX:  cfg_max_mv    = val;
                REG_GUARD_MARGIN: cfg_margin_mv = val;
                default: ;
            endcase
        endfunction

        // Scale the block sum to mV, then percent and plausibility guard
        function t_gauge_reading gauge_reading(logic [CFG_W-1:0] sum);
            logic [63:0]      scaled;
            logic [CFG_W-1:0] volt;
            logic [PCT_W-1:0] pct;
            longint           lo;
            longint           hi;
            t_gauge_reading   r;
            scaled = 64'(sum) * 64'(cfg_gain);
            scaled = scaled / (64'(block_len) << GAIN_FRAC_W);
            volt   = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[CFG_W-1:0];
            // full wins over empty when max is not above min
            if (volt >= cfg_max_mv)
                pct = FULL_PERCENT;
            else if (volt <= cfg_min_mv)
                pct = '0;
            else
                pct = PCT_W'((32'(volt - cfg_min_mv) * 32'(FULL_PERCENT))
                             / 32'(cfg_max_mv - cfg_min_mv));
            lo = longint'(cfg_min_mv) - longint'(cfg_margin_mv);
            hi = longint'(cfg_max_mv) + longint'(cfg_margin_mv);
            if (longint'(volt) < lo || longint'(volt) > hi) begin
                r.voltage_mv     = '0;
                r.charge_percent = '0;
                r.reading_valid  = 1'b0;
            end else begin
                r.voltage_mv     = volt;
                r.charge_percent = pct;
                r.reading_valid  = 1'b1;
            end
            return r;
        endfunction

        // Accepted input transfer: accumulate, owe a reading on block close
        function void take_sample(logic [SAMPLE_W-1:0] s);
            block_sum = block_sum + CFG_W'(s);
            if (block_pos + 1 < block_len) begin
                block_pos++;
                return;
            end
            owed_readings.push_back(gauge_reading(block_sum));
            block_sum = '0;
            block_pos = 0;
        endfunction

        // Accepted output transfer against the oldest owed reading
        function void check_reading(logic [CFG_W-1:0] v, logic [PCT_W-1:0] p, logic ok);
            t_gauge_reading want;
            if (owed_readings.size() == 0) begin
                $display("%0t: unexpected reading: voltage %0d percent %0d valid %0b",
                         $time, v, p, ok);
                error_count++;
                return;
            end
            want = owed_readings.pop_front();
            if (v !== want.voltage_mv) begin
                $display("%0t: voltage_mv expected %0d actual %0d", $time, want.voltage_mv, v);
                error_count++;
            end
            if (p !== want.charge_percent) begin
                $display("%0t: charge_percent expected %0d actual %0d",
                         $time, want.charge_percent, p);
                error_count++;
            end
            if (ok !== want.reading_valid) begin
                $display("%0t: reading_valid expected %0b actual %0b",
                         $time, want.reading_valid, ok);
                error_count++;
            end
        endfunction

        function int owed();
            return owed_readings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    wire  [APB_DATA_W-1:0] prdata;
    wire                   pready;

    bga_in_if  in_if ();
    bga_out_if out_if ();

    t_gauge_checker checker_h;
    int             phase_no;
    int             send_idle_pct;
    int             take_stall_pct;

    battery_gauge_average_percent_core #(
        .SAMPLE_COUNT(BLOCK_LEN)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        checker_h.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // One input transfer, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_mv <= s;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        checker_h.take_sample(s);
    endtask

    // A full block: mostly balanced pairs around a level aimed at a guard or
    // percent boundary, sometimes plain noise
    task automatic send_block();
        logic [SAMPLE_W-1:0] samples [BLOCK_LEN];
        longint target;
        longint base;
        int     spread;
        int     d;
        t_aim   aim;
        if ($urandom_range(99) < 20) begin
            foreach (samples[i]) samples[i] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
        end else begin
            aim = t_aim'($urandom_range(AIM_ANY));
            case (aim)
                AIM_MIN:        target = checker_h.cfg_min_mv;
                AIM_MAX:        target = checker_h.cfg_max_mv;
                AIM_LOW_EDGE:   target = longint'(checker_h.cfg_min_mv) - checker_h.cfg_margin_mv;
                AIM_BELOW_LOW:  target = longint'(checker_h.cfg_min_mv)
                                         - checker_h.cfg_margin_mv - 1;
                AIM_HIGH_EDGE:  target = longint'(checker_h.cfg_max_mv) + checker_h.cfg_margin_mv;
                AIM_ABOVE_HIGH: target = longint'(checker_h.cfg_max_mv)
                                         + checker_h.cfg_margin_mv + 1;
                AIM_MIN_UP:     target = longint'(checker_h.cfg_min_mv) + 1;
                AIM_MAX_DOWN:   target = longint'(checker_h.cfg_max_mv) - 1;
                AIM_BETWEEN:    target = $urandom_range(checker_h.cfg_min_mv,
                                                        checker_h.cfg_max_mv);
                default:        target = $urandom_range(16'hFFFF);
            endcase
            if (target < 0) target = 0;
            if (target > 16'hFFFF) target = 16'hFFFF;
            // level that scales back to the target; exact when gain is unity
            if (checker_h.cfg_gain == '0)
                base = $urandom_range(SAMPLE_MAX);
            else
                base = (target << GAIN_FRAC_W) / checker_h.cfg_gain;
            if (base > SAMPLE_MAX) base = SAMPLE_MAX;
            spread = (base < SAMPLE_MAX - base) ? int'(base) : int'(SAMPLE_MAX - base);
            case ($urandom_range(3))
                0: spread = 0;
                1: if (spread > 3) spread = 3;
                2: if (spread > 200) spread = 200;
                default: ;
            endcase
            // pairs cancel, so the block sum is exactly BLOCK_LEN * base
            for (int i = 0; i < BLOCK_LEN; i += 2) begin
                d = $urandom_range(spread);
                if ($urandom_range(1)) begin
                    samples[i]     = SAMPLE_W'(base + d);
                    samples[i + 1] = SAMPLE_W'(base - d);
                end else begin
                    samples[i]     = SAMPLE_W'(base - d);
                    samples[i + 1] = SAMPLE_W'(base + d);
                end
            end
        end
        foreach (samples[i]) send_sample(samples[i]);
    endtask

    // Let the block finish every reading and settle before a register write
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (checker_h.owed() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register settings per phase: extremes, inverted window, random
    task automatic apply_phase_config(input int p);
        logic [CFG_W-1:0] g, lo_mv, hi_mv, m;
        case (p)
            1:       begin g = 16'd4096;  lo_mv = 16'd3000; hi_mv = 16'd4000;  m = 16'd100;   end
            2:       begin g = 16'hFFFF;  lo_mv = 16'd0;    hi_mv = 16'hFFFF;  m = 16'd0;     end
            3:       begin g = 16'd0;     lo_mv = 16'd0;    hi_mv = 16'd0;     m = 16'd0;     end
            4:       begin g = 16'd4096;  lo_mv = 16'd3500; hi_mv = 16'd2500;  m = 16'hFFFF;  end
            5:       begin
                g     = CFG_W'($urandom_range(16'hFFFF));
                lo_mv = CFG_W'($urandom_range(16'hFFFF));
                hi_mv = CFG_W'($urandom_range(16'hFFFF));
                m     = CFG_W'($urandom_range(16'hFFFF));
            end
            default: begin g = 16'd4096;  lo_mv = 16'd1000; hi_mv = 16'd3000;  m = 16'd200;   end
        endcase
        write_reg(REG_SCALE_GAIN, g);
        write_reg(REG_VOLTAGE_MIN, lo_mv);
        write_reg(REG_VOLTAGE_MAX, hi_mv);
        write_reg(REG_GUARD_MARGIN, m);
    endtask

    // Result side: check each output transfer, stall at random, one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                checker_h.check_reading(out_if.voltage_mv, out_if.charge_percent,
                                        out_if.reading_valid);
            if (!hold_done && phase_no == PRESSURE_PHASE) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) < take_stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        logic [SAMPLE_W-1:0] directed [BLOCK_LEN];
        // extremes and alternating bit patterns; sum lands between min and max
        directed = '{12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h555, 12'hAAA,
                     12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h000, 12'hFFF, 12'h555, 12'hAAA};
        checker_h       = new(BLOCK_LEN);
        phase_no        = 0;
        send_idle_pct   = 0;
        take_stall_pct  = 0;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.sample_mv <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                apply_phase_config(p);
            end
            phase_no = p;
            // idling pattern rotates: none, sender, receiver, both
            case (p % 4)
                0:       begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; take_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  take_stall_pct = 52; end
                default: begin send_idle_pct = 31; take_stall_pct = 31; end
            endcase
            if (p == 0)
                foreach (directed[i]) send_sample(directed[i]);
            repeat (BLOCKS_PER_PHASE) send_block();
        end

        // trailing partial block produces no reading
        repeat ($urandom_range(1, BLOCK_LEN - 1))
            send_sample(SAMPLE_W'($urandom_range(SAMPLE_MAX)));
        in_if.valid <= 1'b0;

        while (checker_h.owed() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_h.error_count == 0)
            $display("battery_gauge_average_percent_core: match");
        else
            $display("battery_gauge_average_percent_core: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #200000;
        $display("battery_gauge_average_percent_core: mismatch");
        $finish;
    end

endmodule
